// ----- rtl/core/svg_pkg.sv -----
// Shared constants, types and helper functions for the sphere vertex generator.
package svg_pkg;

  // Fixed-point formats and unit sizes
  localparam int unsigned ANGLE_FRAC_BITS = 16;
  localparam int unsigned CORDIC_STAGES   = 16;
  localparam int unsigned ATAN_ENTRIES    = 24;
  localparam int unsigned SHIFT_W         = $clog2(ATAN_ENTRIES);

  // Angle divider: quotient bits, divisor and remainder widths
  localparam int unsigned DEN_W  = 15;
  localparam int unsigned REM_W  = DEN_W + 1;
  localparam int unsigned QUO_W  = ANGLE_FRAC_BITS + 4;
  localparam int unsigned NUM_W  = QUO_W + REM_W;
  localparam int unsigned PROD_W = 19;

  // Q30 angle widths
  localparam int unsigned Q30_SHIFT = 30 - ANGLE_FRAC_BITS;
  localparam int unsigned AQ_W      = QUO_W + Q30_SHIFT;
  localparam int unsigned ZU_W      = 33;
  localparam int unsigned FOLD_W    = ZU_W + 2;
  localparam int unsigned Z_W       = 33;
  localparam int unsigned XY_W      = 32;

  // Output arithmetic widths
  localparam int unsigned DS_W  = 17;
  localparam int unsigned PX_W  = DS_W + XY_W;
  localparam int unsigned T_W   = 19;
  localparam int unsigned PM_W  = T_W + XY_W;
  localparam int unsigned SAT_W = PM_W - 31;

  // Angle scale factors (3.14 kept as 314/100)
  localparam int unsigned SEC_SCALE = 628;
  localparam int unsigned SPL_SCALE = 157;
  localparam int unsigned DEN_SCALE = 100;

  localparam logic [ZU_W-1:0] PI_Q30       = ZU_W'(64'd3373259426);
  localparam logic [ZU_W-1:0] HALF_PI_Q30  = ZU_W'(64'd1686629713);
  localparam logic [ZU_W-1:0] PI_3HALF_Q30 = ZU_W'(64'd5059889139);
  localparam logic [ZU_W-1:0] TWO_PI_Q30   = ZU_W'(64'd6746518852);
  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = XY_W'(652032874);

  // Configuration registers
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_DIAMETER = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SECTIONS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPLICES  = 2'd2;

  localparam logic [15:0] DIAMETER_RESET = 16'd256;
  localparam logic [7:0]  SECTIONS_RESET = 8'd16;
  localparam logic [7:0]  SPLICES_RESET  = 8'd8;

  // Control bits that travel beside each request
  typedef struct packed {
    logic vld;
    logic err;
  } side_t;

  // Arctangent of 2^-idx in Q30
  function automatic logic [29:0] atan_q30(input logic [SHIFT_W-1:0] idx);
    logic [29:0] val;
    case (idx)
      5'd0:  val = 30'd843314857;
      5'd1:  val = 30'd497837830;
      5'd2:  val = 30'd263043837;
      5'd3:  val = 30'd133525159;
      5'd4:  val = 30'd67021687;
      5'd5:  val = 30'd33543516;
      5'd6:  val = 30'd16775851;
      5'd7:  val = 30'd8388437;
      5'd8:  val = 30'd4194283;
      5'd9:  val = 30'd2097149;
      5'd10: val = 30'd1048576;
      5'd11: val = 30'd524288;
      5'd12: val = 30'd262144;
      5'd13: val = 30'd131072;
      5'd14: val = 30'd65536;
      5'd15: val = 30'd32768;
      5'd16: val = 30'd16384;
      5'd17: val = 30'd8192;
      5'd18: val = 30'd4096;
      5'd19: val = 30'd2048;
      5'd20: val = 30'd1024;
      5'd21: val = 30'd512;
      5'd22: val = 30'd256;
      5'd23: val = 30'd128;
      default: val = 30'd0;
    endcase
    return val;
  endfunction

  // Clamp to the signed 16-bit range
  function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] v);
    logic signed [15:0] res;
    if (v > signed'(SAT_W'(32767))) begin
      res = 16'sd32767;
    end else if (v < signed'(SAT_W'(-32768))) begin
      res = -16'sd32768;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/svg_div_cell.sv -----
// One restoring-division cell: develops one quotient bit per clock.
module svg_div_cell (
  input  logic                       clk_i,
  input  logic [svg_pkg::DEN_W-1:0]  den_i,
  input  logic [svg_pkg::REM_W-1:0]  rem_i,
  input  logic [svg_pkg::QUO_W-1:0]  nq_i,
  output logic [svg_pkg::REM_W-1:0]  rem_o,
  output logic [svg_pkg::QUO_W-1:0]  nq_o
);

  logic [svg_pkg::REM_W-1:0] rem_shift;
  logic [svg_pkg::REM_W-1:0] rem_diff;
  logic                      take;
  logic [svg_pkg::REM_W-1:0] rem_q;
  logic [svg_pkg::QUO_W-1:0] nq_q;

  // Shift in the next dividend bit and try the subtract
  assign rem_shift = {rem_i[svg_pkg::REM_W-2:0], nq_i[svg_pkg::QUO_W-1]};
  assign take      = rem_shift >= {1'b0, den_i};
  assign rem_diff  = rem_shift - {1'b0, den_i};

  // Hand the partial remainder and the quotient bits to the next cell
  always_ff @(posedge clk_i) begin
    rem_q <= take ? rem_diff : rem_shift;
    nq_q  <= {nq_i[svg_pkg::QUO_W-2:0], take};
  end

  assign rem_o = rem_q;
  assign nq_o  = nq_q;

endmodule

// ----- rtl/core/svg_cordic_cell.sv -----
// One rotation-mode CORDIC micro-rotation, registered.
module svg_cordic_cell (
  input  logic                              clk_i,
  input  logic [svg_pkg::SHIFT_W-1:0]       shift_i,
  input  logic signed [svg_pkg::XY_W-1:0]   x_i,
  input  logic signed [svg_pkg::XY_W-1:0]   y_i,
  input  logic signed [svg_pkg::Z_W-1:0]    z_i,
  input  logic                              flip_i,
  output logic signed [svg_pkg::XY_W-1:0]   x_o,
  output logic signed [svg_pkg::XY_W-1:0]   y_o,
  output logic signed [svg_pkg::Z_W-1:0]    z_o,
  output logic                              flip_o
);

  logic signed [svg_pkg::XY_W-1:0] x_sh;
  logic signed [svg_pkg::XY_W-1:0] y_sh;
  logic signed [svg_pkg::Z_W-1:0]  atan_val;
  logic signed [svg_pkg::XY_W-1:0] x_q;
  logic signed [svg_pkg::XY_W-1:0] y_q;
  logic signed [svg_pkg::Z_W-1:0]  z_q;
  logic                            flip_q;

  assign x_sh     = x_i >>> shift_i;
  assign y_sh     = y_i >>> shift_i;
  assign atan_val = signed'(svg_pkg::Z_W'(svg_pkg::atan_q30(shift_i)));

  // Rotate toward zero residual angle
  always_ff @(posedge clk_i) begin
    if (!z_i[svg_pkg::Z_W-1]) begin
      x_q <= x_i - y_sh;
      y_q <= y_i + x_sh;
      z_q <= z_i - atan_val;
    end else begin
      x_q <= x_i + y_sh;
      y_q <= y_i - x_sh;
      z_q <= z_i + atan_val;
    end
    flip_q <= flip_i;
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign flip_o = flip_q;

endmodule

// ----- rtl/core/sphere_vertex_generator.sv -----
// Top level: config registers, angle dividers, CORDIC chains and vertex scaling.
// Pipeline from the start request to done_o: one input stage, 20 divider cells,
// two angle reduction stages, 16 CORDIC cells, five multiply and round stages.
// Throughput: one request per cycle; busy stays low, done_o pulses for one cycle.
// Reset clears the pipeline valid bits and loads the register reset values.
module sphere_vertex_generator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [8:0]                         section_index_i,
  input  logic [7:0]                         splice_index_i,
  output logic                               done_o,
  output logic signed [15:0]                 coord_x_o,
  output logic signed [15:0]                 coord_y_o,
  output logic signed [15:0]                 coord_z_o,
  output logic                               index_error_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [svg_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned QW  = svg_pkg::QUO_W;
  localparam int unsigned CS  = svg_pkg::CORDIC_STAGES;
  localparam int unsigned LAT = QW + CS + 8;
  localparam int unsigned LANE_SEC = 0;
  localparam int unsigned LANE_SPL = 1;

  localparam logic signed [svg_pkg::PX_W-1:0] PX_RND30 =
    signed'(svg_pkg::PX_W'(64'd1) << 29);
  localparam logic signed [svg_pkg::PX_W-1:0] PX_RND31 =
    signed'(svg_pkg::PX_W'(64'd1) << 30);
  localparam logic signed [svg_pkg::PM_W-1:0] PM_RND31 =
    signed'(svg_pkg::PM_W'(64'd1) << 30);

  // Configuration registers
  logic [15:0] diameter_q;
  logic [7:0]  section_count_q;
  logic [7:0]  splice_count_q;
  logic        cfg_wr;
  logic [svg_pkg::REG_IDX_W-1:0] cfg_idx;

  // Input stage
  logic                        acc;
  logic                        err_in;
  logic [svg_pkg::PROD_W-1:0]  prod [2];
  logic [svg_pkg::NUM_W-1:0]   num [2];
  logic [svg_pkg::DEN_W-1:0]   den [2];
  logic                        den_zero [2];
  logic [svg_pkg::REM_W-1:0]   rem0_q [2];
  logic [QW-1:0]               nq0_q [2];

  // Divider chains
  logic [svg_pkg::REM_W-1:0]   rem_w [2][QW+1];
  logic [QW-1:0]               nq_w [2][QW+1];

  // Angle reduction
  logic [svg_pkg::AQ_W-1:0]    aq [2];
  logic [svg_pkg::AQ_W-1:0]    red [2];
  logic [svg_pkg::ZU_W-1:0]    ang_q [2];
  logic [svg_pkg::FOLD_W-1:0]  fold_t [2];
  logic                        fold_flip [2];
  logic signed [svg_pkg::Z_W-1:0] fz_q [2];
  logic                        ff_q [2];

  // CORDIC chains
  logic signed [svg_pkg::XY_W-1:0] x_w [2][CS+1];
  logic signed [svg_pkg::XY_W-1:0] y_w [2][CS+1];
  logic signed [svg_pkg::Z_W-1:0]  z_w [2][CS+1];
  logic                            flip_w [2][CS+1];

  // Scaling stages
  logic signed [svg_pkg::XY_W-1:0] s_q [2];
  logic signed [svg_pkg::XY_W-1:0] c_q [2];
  logic signed [svg_pkg::DS_W-1:0] diam_s;
  logic signed [svg_pkg::PX_W-1:0] pxa_q;
  logic signed [svg_pkg::PX_W-1:0] pza_q;
  logic signed [svg_pkg::PX_W-1:0] pyb_q;
  logic signed [svg_pkg::XY_W-1:0] cb2_q;
  logic signed [svg_pkg::PX_W-1:0] rx_sum;
  logic signed [svg_pkg::PX_W-1:0] rz_sum;
  logic signed [svg_pkg::PX_W-1:0] ry_sum;
  logic signed [svg_pkg::PX_W-1:0] rx_shr;
  logic signed [svg_pkg::PX_W-1:0] rz_shr;
  logic signed [svg_pkg::PX_W-1:0] ry_shr;
  logic signed [svg_pkg::T_W-1:0]  tx_q;
  logic signed [svg_pkg::T_W-1:0]  tz_q;
  logic signed [svg_pkg::T_W-1:0]  ty_q;
  logic signed [svg_pkg::XY_W-1:0] cb3_q;
  logic signed [svg_pkg::PM_W-1:0] pxx_q;
  logic signed [svg_pkg::PM_W-1:0] pzz_q;
  logic signed [15:0]              yn_q;
  logic signed [svg_pkg::SAT_W-1:0] yneg;
  logic signed [svg_pkg::PM_W-1:0] ox_sum;
  logic signed [svg_pkg::PM_W-1:0] oz_sum;
  logic signed [svg_pkg::PM_W-1:0] ox_shr;
  logic signed [svg_pkg::PM_W-1:0] oz_shr;
  logic signed [15:0]              coord_x_q;
  logic signed [15:0]              coord_y_q;
  logic signed [15:0]              coord_z_q;

  svg_pkg::side_t side_q [LAT];

  // Register port: every write completes in its access cycle
  assign pready  = 1'b1;
  assign cfg_idx = paddr[svg_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diameter_q      <= svg_pkg::DIAMETER_RESET;
      section_count_q <= svg_pkg::SECTIONS_RESET;
      splice_count_q  <= svg_pkg::SPLICES_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        svg_pkg::REG_DIAMETER: diameter_q      <= pwdata[15:0];
        svg_pkg::REG_SECTIONS: section_count_q <= pwdata[7:0];
        svg_pkg::REG_SPLICES:  splice_count_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      svg_pkg::REG_DIAMETER: prdata = {16'd0, diameter_q};
      svg_pkg::REG_SECTIONS: prdata = {24'd0, section_count_q};
      svg_pkg::REG_SPLICES:  prdata = {24'd0, splice_count_q};
      default:               prdata = 32'd0;
    endcase
  end

  // Request handshake: a new request every cycle
  assign busy = 1'b0;
  assign acc  = start && !busy;

  assign err_in = (section_index_i > (9'(section_count_q) + 9'd1)) ||
                  (splice_index_i >= splice_count_q);

  // Divisors and dividends of both angles
  always_comb begin
    den[LANE_SEC] = svg_pkg::DEN_W'(section_count_q) *
                    svg_pkg::DEN_W'(svg_pkg::DEN_SCALE);
    den[LANE_SPL] = svg_pkg::DEN_W'(8'(splice_count_q - 8'd1)) *
                    svg_pkg::DEN_W'(svg_pkg::DEN_SCALE);
    den_zero[LANE_SEC] = (section_count_q == 8'd0);
    den_zero[LANE_SPL] = (splice_count_q == 8'd1);
    prod[LANE_SEC] = svg_pkg::PROD_W'(section_index_i) *
                     svg_pkg::PROD_W'(svg_pkg::SEC_SCALE);
    prod[LANE_SPL] = svg_pkg::PROD_W'(splice_index_i) *
                     svg_pkg::PROD_W'(svg_pkg::SPL_SCALE);
    for (int l = 0; l < 2; l++) begin
      num[l] = (svg_pkg::NUM_W'(prod[l]) << svg_pkg::ANGLE_FRAC_BITS) +
               svg_pkg::NUM_W'(den[l] >> 1);
    end
  end

  // Load the divider heads
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      rem0_q[l] <= num[l][svg_pkg::NUM_W-1 -: svg_pkg::REM_W];
      nq0_q[l]  <= num[l][QW-1:0];
    end
  end

  // Reduce the angle to one turn in Q30
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      aq[l] = svg_pkg::AQ_W'(nq_w[l][QW]) << svg_pkg::Q30_SHIFT;
      if (den_zero[l]) begin
        aq[l] = '0;
      end
      red[l] = (aq[l] >= svg_pkg::AQ_W'(svg_pkg::TWO_PI_Q30)) ?
               aq[l] - svg_pkg::AQ_W'(svg_pkg::TWO_PI_Q30) : aq[l];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      ang_q[l] <= red[l][svg_pkg::ZU_W-1:0];
    end
  end

  // Fold into the right half-plane, remembering a half-turn flip
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      fold_flip[l] = 1'b0;
      if (ang_q[l] > svg_pkg::HALF_PI_Q30 && ang_q[l] <= svg_pkg::PI_3HALF_Q30) begin
        fold_t[l]    = svg_pkg::FOLD_W'(ang_q[l]) - svg_pkg::FOLD_W'(svg_pkg::PI_Q30);
        fold_flip[l] = 1'b1;
      end else if (ang_q[l] > svg_pkg::PI_3HALF_Q30) begin
        fold_t[l] = svg_pkg::FOLD_W'(ang_q[l]) - svg_pkg::FOLD_W'(svg_pkg::TWO_PI_Q30);
      end else begin
        fold_t[l] = svg_pkg::FOLD_W'(ang_q[l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      fz_q[l] <= signed'(fold_t[l][svg_pkg::Z_W-1:0]);
      ff_q[l] <= fold_flip[l];
    end
  end

  // Two lanes: section angle and splice angle
  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign rem_w[l][0] = rem0_q[l];
    assign nq_w[l][0]  = nq0_q[l];

    for (genvar k = 0; k < QW; k++) begin : g_div
      svg_div_cell u_div (
        .clk_i (clk_i),
        .den_i (den[l]),
        .rem_i (rem_w[l][k]),
        .nq_i  (nq_w[l][k]),
        .rem_o (rem_w[l][k+1]),
        .nq_o  (nq_w[l][k+1])
      );
    end

    assign x_w[l][0]    = svg_pkg::CORDIC_GAIN_Q30;
    assign y_w[l][0]    = '0;
    assign z_w[l][0]    = fz_q[l];
    assign flip_w[l][0] = ff_q[l];

    for (genvar k = 0; k < CS; k++) begin : g_rot
      svg_cordic_cell u_rot (
        .clk_i   (clk_i),
        .shift_i (svg_pkg::SHIFT_W'(k)),
        .x_i     (x_w[l][k]),
        .y_i     (y_w[l][k]),
        .z_i     (z_w[l][k]),
        .flip_i  (flip_w[l][k]),
        .x_o     (x_w[l][k+1]),
        .y_o     (y_w[l][k+1]),
        .z_o     (z_w[l][k+1]),
        .flip_o  (flip_w[l][k+1])
      );
    end
  end

  // Apply the half-turn flip to sine and cosine
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      s_q[l] <= flip_w[l][CS] ? -y_w[l][CS] : y_w[l][CS];
      c_q[l] <= flip_w[l][CS] ? -x_w[l][CS] : x_w[l][CS];
    end
  end

  // Scale by the diameter
  assign diam_s = signed'({1'b0, diameter_q});

  always_ff @(posedge clk_i) begin
    pxa_q <= diam_s * s_q[LANE_SEC];
    pza_q <= diam_s * c_q[LANE_SEC];
    pyb_q <= diam_s * s_q[LANE_SPL];
    cb2_q <= c_q[LANE_SPL];
  end

  // Round half away from zero to Q8
  always_comb begin
    rx_sum = pxa_q + (pxa_q[svg_pkg::PX_W-1] ? PX_RND30 - 1 : PX_RND30);
    rz_sum = pza_q + (pza_q[svg_pkg::PX_W-1] ? PX_RND30 - 1 : PX_RND30);
    ry_sum = pyb_q + (pyb_q[svg_pkg::PX_W-1] ? PX_RND31 - 1 : PX_RND31);
    rx_shr = rx_sum >>> 30;
    rz_shr = rz_sum >>> 30;
    ry_shr = ry_sum >>> 31;
  end

  always_ff @(posedge clk_i) begin
    tx_q  <= rx_shr[svg_pkg::T_W-1:0];
    tz_q  <= rz_shr[svg_pkg::T_W-1:0];
    ty_q  <= ry_shr[svg_pkg::T_W-1:0];
    cb3_q <= cb2_q;
  end

  // Multiply by cos(b); negate and clamp y
  assign yneg = -svg_pkg::SAT_W'(ty_q);

  always_ff @(posedge clk_i) begin
    pxx_q <= tx_q * cb3_q;
    pzz_q <= tz_q * cb3_q;
    yn_q  <= svg_pkg::sat16(yneg);
  end

  // Round, clamp and zero out failed requests
  always_comb begin
    ox_sum = pxx_q + (pxx_q[svg_pkg::PM_W-1] ? PM_RND31 - 1 : PM_RND31);
    oz_sum = pzz_q + (pzz_q[svg_pkg::PM_W-1] ? PM_RND31 - 1 : PM_RND31);
    ox_shr = ox_sum >>> 31;
    oz_shr = oz_sum >>> 31;
  end

  always_ff @(posedge clk_i) begin
    if (side_q[LAT-2].err) begin
      coord_x_q <= '0;
      coord_y_q <= '0;
      coord_z_q <= '0;
    end else begin
      coord_x_q <= svg_pkg::sat16(ox_shr[svg_pkg::SAT_W-1:0]);
      coord_y_q <= yn_q;
      coord_z_q <= svg_pkg::sat16(oz_shr[svg_pkg::SAT_W-1:0]);
    end
  end

  // Advance the valid and error bits beside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) begin
        side_q[k] <= '0;
      end
    end else begin
      side_q[0] <= '{vld: acc, err: err_in};
      for (int k = 1; k < LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign done_o        = side_q[LAT-1].vld;
  assign index_error_o = side_q[LAT-1].err;
  assign coord_x_o     = coord_x_q;
  assign coord_y_o     = coord_y_q;
  assign coord_z_o     = coord_z_q;

  // A result only follows a request taken a fixed latency earlier
  a_done_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, LAT))
    else $error("result without a matching request");

  // The error flag matches the range check made when the request was taken
  a_error_tracks_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (index_error_o == $past(err_in, LAT)))
    else $error("error flag does not match request");

  // A failed request gives a zero vertex
  a_error_zero_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && index_error_o) |->
      (coord_x_o == 16'sd0 && coord_y_o == 16'sd0 && coord_z_o == 16'sd0))
    else $error("nonzero coordinates on index error");

  // A diameter write lands in the register
  a_diameter_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && cfg_idx == svg_pkg::REG_DIAMETER) |=> (diameter_q == $past(pwdata[15:0])))
    else $error("diameter write lost");

endmodule
